// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge once out of reset.
`define SFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Same-cycle implication, antecedent and consequent given apart.
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ----- hdl/sfr_pkg.sv -----
// Shared constants and controller/datapath interface types for the frame receiver.
package sfr_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int LEN_CAP     = 16;
    localparam int CAP_INT     = (MAX_PAYLOAD < LEN_CAP) ? MAX_PAYLOAD : LEN_CAP;
    localparam logic [4:0] LEN_CAP_LIMIT = 5'(CAP_INT);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPES    = 2'd3;

    localparam logic [7:0]  SYNC_RESET     = 8'hFC;
    localparam logic [15:0] PREAMBLE_RESET = 16'h027A;
    localparam logic [4:0]  MAX_LEN_RESET  = 5'd16;
    localparam logic [63:0] TYPES_RESET    = 64'd8888832818159968577;

    localparam logic [7:0] CK_BASE = 8'hFC;

    // Commands from controller to datapath
    typedef struct packed {
        logic sum_init;
        logic sum_add;
        logic type_load;
        logic len_load;
        logic pay_write;
        logic drain_start;
        logic drain_step;
    } sfr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sync_hit;
        logic type_hit;
        logic pre_hi_hit;
        logic pre_lo_hit;
        logic len_ok;
        logic len_zero;
        logic pay_last;
        logic ck_hit;
        logic drain_last;
        logic out_free;
    } sfr_status_t;

endpackage

// ----- hdl/serial_frame_receiver.sv -----
// Top level of the byte-serial frame receiver with additive checksum.
// Throughput: header, payload and checksum beats are taken one per cycle; after a good
//   checksum the input stalls while the results drain, until the frame's last result
//   has been loaded into the result register.
// Result path: with the result side free, the checksum beat moves the controller to its
//   drain state, from which the first result is loaded into the result register.
// Reset (rst_n, async, low): frame parser back to waiting for sync, result register
//   empty, configuration registers at their defaults; the payload store is not cleared.
module serial_frame_receiver
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input beats
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    // result beats
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     frame_type,
    output logic [4:0]                     frame_length,
    output logic [3:0]                     byte_index,
    output logic [7:0]                     data_byte,
    output logic                           has_data,
    output logic                           last
);

    // Controller tracks frame position and drain; datapath holds every value.
    sfr_pkg::sfr_cmd_t    cmd;
    sfr_pkg::sfr_status_t status;

    sfr_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // The drain steps only when the result register is empty or being taken,
    // so a stalled beat is never overwritten; the last beat of a frame may
    // still wait while the parser takes the next frame.
    sfr_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .last         (last)
    );

endmodule

// ----- hdl/sfr_datapath.sv -----
// Datapath: configuration, header checks, checksum, payload store and result register.
module sfr_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        rx_byte,
    input  logic                              cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              out_stall,
    input  sfr_pkg::sfr_cmd_t                 cmd,
    output sfr_pkg::sfr_status_t              status,
    output logic                              out_valid,
    output logic [7:0]                        frame_type,
    output logic [4:0]                        frame_length,
    output logic [3:0]                        byte_index,
    output logic [7:0]                        data_byte,
    output logic                              has_data,
    output logic                              last
);

    logic [7:0]  sync_reg;
    logic [15:0] preamble_reg;
    logic [4:0]  max_len_reg;
    logic [63:0] types_reg;

    logic [7:0]  sum_reg;
    logic [7:0]  type_reg;
    logic [4:0]  len_reg;
    logic [3:0]  count_reg;
    logic [7:0]  store_reg [sfr_pkg::LEN_CAP];

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_type_reg;
    logic [4:0]  out_len_reg;
    logic [3:0]  out_idx_reg;
    logic [7:0]  out_data_reg;
    logic        out_has_reg;
    logic        out_last_reg;

    logic [4:0]  limit;
    logic        type_hit;
    logic [4:0]  count_inc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg     <= sfr_pkg::SYNC_RESET;
            preamble_reg <= sfr_pkg::PREAMBLE_RESET;
            max_len_reg  <= sfr_pkg::MAX_LEN_RESET;
            types_reg    <= sfr_pkg::TYPES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfr_pkg::CFG_SYNC:     sync_reg     <= cfg_data[7:0];
                sfr_pkg::CFG_PREAMBLE: preamble_reg <= cfg_data[15:0];
                sfr_pkg::CFG_MAX_LEN:  max_len_reg  <= cfg_data[4:0];
                sfr_pkg::CFG_TYPES:    types_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Byte checks
    always_comb
    begin
        type_hit = 1'b0;
        for (int lane = 0; lane < 8; lane++)
        begin
            if (types_reg[lane*8 +: 8] == rx_byte)
                type_hit = 1'b1;
        end
    end

    assign limit     = (max_len_reg > sfr_pkg::LEN_CAP_LIMIT) ? sfr_pkg::LEN_CAP_LIMIT
                                                              : max_len_reg;
    assign count_inc = {1'b0, count_reg} + 5'd1;

    assign status.sync_hit   = (rx_byte == sync_reg);
    assign status.type_hit   = type_hit;
    assign status.pre_hi_hit = (rx_byte == preamble_reg[15:8]);
    assign status.pre_lo_hit = (rx_byte == preamble_reg[7:0]);
    assign status.len_ok     = (rx_byte <= {3'b000, limit});
    assign status.len_zero   = (rx_byte == 8'd0);
    assign status.pay_last   = (count_inc == len_reg);
    assign status.ck_hit     = (8'(sfr_pkg::CK_BASE - sum_reg) == rx_byte);
    assign status.drain_last = (len_reg == 5'd0) || (count_inc == len_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    // Frame registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= 8'd0;
            type_reg  <= 8'd0;
            len_reg   <= 5'd0;
            count_reg <= 4'd0;
        end
        else
        begin
            if (cmd.sum_init)
                sum_reg <= rx_byte;
            else if (cmd.sum_add)
                sum_reg <= sum_reg + rx_byte;
            if (cmd.type_load)
                type_reg <= rx_byte;
            if (cmd.len_load)
                len_reg <= rx_byte[4:0];
            if (cmd.len_load || cmd.drain_start)
                count_reg <= 4'd0;
            else if (cmd.pay_write || cmd.drain_step)
                count_reg <= count_reg + 4'd1;
        end
    end

    // Payload store, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.pay_write)
            store_reg[count_reg] <= rx_byte;
    end

    // Result register
    always_comb
    begin
        if (cmd.drain_step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain_step)
        begin
            out_type_reg <= type_reg;
            out_len_reg  <= len_reg;
            out_idx_reg  <= count_reg;
            out_has_reg  <= (len_reg != 5'd0);
            out_data_reg <= (len_reg != 5'd0) ? store_reg[count_reg] : 8'd0;
            out_last_reg <= status.drain_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_type   = out_type_reg;
    assign frame_length = out_len_reg;
    assign byte_index   = out_idx_reg;
    assign data_byte    = out_data_reg;
    assign has_data     = out_has_reg;
    assign last         = out_last_reg;

endmodule

// ----- hdl/sfr_controller.sv -----
// Controller: frame position state machine and result drain sequencing.
module sfr_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sfr_pkg::sfr_status_t status,
    output sfr_pkg::sfr_cmd_t    cmd,
    output logic                 in_stall
);

    localparam logic [2:0] ST_SYNC    = 3'd0;
    localparam logic [2:0] ST_TYPE    = 3'd1;
    localparam logic [2:0] ST_PRE_HI  = 3'd2;
    localparam logic [2:0] ST_PRE_LO  = 3'd3;
    localparam logic [2:0] ST_LEN     = 3'd4;
    localparam logic [2:0] ST_PAYLOAD = 3'd5;
    localparam logic [2:0] ST_CHECK   = 3'd6;
    localparam logic [2:0] ST_DRAIN   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       take;

    assign in_stall = (state_reg == ST_DRAIN);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SYNC:
            begin
                if (take && status.sync_hit)
                begin
                    cmd.sum_init = 1'b1;
                    state_next   = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                if (take)
                begin
                    if (status.type_hit)
                    begin
                        cmd.type_load = 1'b1;
                        cmd.sum_add   = 1'b1;
                        state_next    = ST_PRE_HI;
                    end
                    else
                        state_next = ST_SYNC;
                end
            end
            ST_PRE_HI:
            begin
                if (take)
                begin
                    cmd.sum_add = 1'b1;
                    state_next  = status.pre_hi_hit ? ST_PRE_LO : ST_SYNC;
                end
            end
            ST_PRE_LO:
            begin
                if (take)
                begin
                    cmd.sum_add = 1'b1;
                    state_next  = status.pre_lo_hit ? ST_LEN : ST_SYNC;
                end
            end
            ST_LEN:
            begin
                if (take)
                begin
                    if (status.len_ok)
                    begin
                        cmd.len_load = 1'b1;
                        cmd.sum_add  = 1'b1;
                        state_next   = status.len_zero ? ST_CHECK : ST_PAYLOAD;
                    end
                    else
                        state_next = ST_SYNC;
                end
            end
            ST_PAYLOAD:
            begin
                if (take)
                begin
                    cmd.pay_write = 1'b1;
                    cmd.sum_add   = 1'b1;
                    if (status.pay_last)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (take)
                begin
                    if (status.ck_hit)
                    begin
                        cmd.drain_start = 1'b1;
                        state_next      = ST_DRAIN;
                    end
                    else
                        state_next = ST_SYNC;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.drain_step = 1'b1;
                    if (status.drain_last)
                        state_next = ST_SYNC;
                end
            end
            default:
                state_next = ST_SYNC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SYNC;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hdl/sfr_checker.sv -----
// Port-level checker for the frame receiver, bound to the top level.
`include "assert_macros.svh"

module sfr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [7:0]                     rx_byte,
    input logic                           cfg_we,
    input logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [7:0]                     frame_type,
    input logic [4:0]                     frame_length,
    input logic [3:0]                     byte_index,
    input logic [7:0]                     data_byte,
    input logic                           has_data,
    input logic                           last
);

    logic mid_frame_beat;

    assign mid_frame_beat = out_valid && !out_stall && !last;

    // a stalled result beat stays offered
    `SFR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // an empty frame gives a single beat with no data
    `SFR_ASSERT_IMP(a_empty_last, clk, rst_n, out_valid && !has_data, last && data_byte == 8'd0)
    // data beats lie inside the frame
    `SFR_ASSERT_IMP(a_idx_range, clk, rst_n, out_valid && has_data, {1'b0, byte_index} < frame_length)
    // inside a frame the next beat follows at once; input held off until the last one
    `SFR_ASSERT_NXT(a_drain_cont, clk, rst_n, mid_frame_beat, out_valid && (in_stall || last))

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

// ----- tb/serial_frame_receiver_test.sv -----
// Self-checking testbench for the byte-serial frame receiver.
`timescale 1ns / 1ps

module serial_frame_receiver_test;

    localparam int SETTLE      = 8;     // cycles after the last result before a register write
    localparam int QUIET_LIMIT = 2000;  // cycles with no beat and no write before giving up
    localparam int PHASE_BYTES = 58;    // random rx bytes per register setting

    // One result beat as the block presents it
    typedef struct packed {
        logic [7:0] kind;
        logic [4:0] len;
        logic [3:0] pos;
        logic [7:0] value;
        logic       with_data;
        logic       tail;
    } frame_beat_t;

    // Directed rows carry a typed-in outcome: either no result, or one empty-frame beat
    typedef enum logic {CHK_NONE, CHK_EMPTY} row_check_t;

    typedef struct {
        logic [0:5][7:0] seq;
        int              n;
        row_check_t      check;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        cfg_we = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index = sfr_pkg::CFG_SYNC;
    logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_type;
    logic [4:0]  frame_length;
    logic [3:0]  byte_index;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        last;

    // Register copies held by the predictor
    logic [7:0]  reg_sync;
    logic [15:0] reg_preamble;
    logic [4:0]  reg_max_len;
    logic [63:0] reg_types;

    // Predictor state
    logic [4:0]  frame_pos;
    logic [4:0]  frame_len;
    logic [7:0]  frame_sum;
    logic [7:0]  cur_type;
    logic [7:0]  payload_mem [16];

    frame_beat_t frame_out [$];   // beats released by the byte just taken
    frame_beat_t due_beats [$];   // beats still owed by the block, oldest first
    logic [7:0]  frame_bytes [$]; // byte sequence of the frame being sent
    stim_row_t   stim_rows [$];

    int in_idle_pct  = 16;
    int out_idle_pct = 60;
    int mismatches    = 0;
    int beats_checked = 0;
    int frames_out    = 0;
    int bytes_sent    = 0;
    int settings_run  = 0;
    int quiet_cycles  = 0;

    serial_frame_receiver dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .last         (last)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] check_of(input logic [7:0] sum);
        return sfr_pkg::CK_BASE - sum;
    endfunction

    function automatic bit type_known(input logic [7:0] t);
        for (int lane = 0; lane < 8; lane++)
        begin
            if (reg_types[8*lane +: 8] == t)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Effective length cap: register value, clipped to the store depth
    function automatic int len_limit();
        return (int'(reg_max_len) < int'(sfr_pkg::LEN_CAP_LIMIT))
               ? int'(reg_max_len) : int'(sfr_pkg::LEN_CAP_LIMIT);
    endfunction

    function automatic logic [7:0] unknown_type();
        logic [7:0] t;
        do
            t = 8'($urandom);
        while (type_known(t));
        return t;
    endfunction

    function automatic void model_reset();
        reg_sync     = sfr_pkg::SYNC_RESET;
        reg_preamble = sfr_pkg::PREAMBLE_RESET;
        reg_max_len  = sfr_pkg::MAX_LEN_RESET;
        reg_types    = sfr_pkg::TYPES_RESET;
        frame_pos    = 5'd0;
        frame_len    = 5'd0;
        frame_sum    = 8'h00;
        cur_type     = 8'h00;
        foreach (payload_mem[i])
            payload_mem[i] = 8'h00;
    endfunction

    // Advance the parser by one rx byte; any beats it releases land in frame_out
    function automatic void deframe_byte(input logic [7:0] b);
        bit keep;
        bit drop;
        keep = 1'b0;
        drop = 1'b0;
        frame_out.delete();
        case (frame_pos)
            5'd0:
            begin
                // hunting for sync, anything else is ignored
                if (b == reg_sync)
                begin
                    frame_sum = b;
                    frame_pos = 5'd1;
                end
            end
            5'd1:
            begin
                keep = type_known(b);
                drop = !keep;
                if (keep)
                    cur_type = b;
            end
            5'd2:
            begin
                keep = (b == reg_preamble[15:8]);
                drop = !keep;
            end
            5'd3:
            begin
                keep = (b == reg_preamble[7:0]);
                drop = !keep;
            end
            5'd4:
            begin
                keep = (int'(b) <= len_limit());
                drop = !keep;
                if (keep)
                    frame_len = b[4:0];
            end
            default:
            begin
                if (frame_pos < 5'd5 + frame_len)
                begin
                    payload_mem[4'(frame_pos - 5'd5)] = b;
                    keep = 1'b1;
                end
                else
                begin
                    // checksum byte closes the frame whatever its value
                    drop = 1'b1;
                    if (b == check_of(frame_sum))
                    begin
                        if (frame_len == 5'd0)
                            frame_out.push_back('{cur_type, 5'd0, 4'd0, 8'd0, 1'b0, 1'b1});
                        for (int k = 0; k < frame_len; k++)
                            frame_out.push_back('{cur_type, frame_len, 4'(k), payload_mem[k],
                                                  1'b1, k == frame_len - 1});
                    end
                end
            end
        endcase
        if (keep)
        begin
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 5'd1;
        end
        else if (drop)
            frame_pos = 5'd0;
    endfunction

    // A byte that drops a part-built frame, or in the payload fills it toward a wrong checksum
    function automatic logic [7:0] leave_frame_byte();
        case (frame_pos)
            5'd1:    return unknown_type();
            5'd2:    return ~reg_preamble[15:8];
            5'd3:    return ~reg_preamble[7:0];
            5'd4:    return 8'hFF;
            default:
            begin
                if (frame_pos < 5'd5 + frame_len)
                    return 8'h00;
                return ~check_of(frame_sum);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Header-only row: lead byte (sync or noise), type, preamble, length, checksum.
    // The first n bytes are sent.
    function automatic stim_row_t make_row(input logic [7:0] lead, input logic [7:0] ft,
                                           input logic [15:0] pre, input logic [7:0] len_b,
                                           input logic [7:0] ck_flip, input int n,
                                           input row_check_t chk);
        stim_row_t row;
        row.seq   = {lead, ft, pre, len_b,
                     check_of(lead + ft + pre[15:8] + pre[7:0] + len_b) ^ ck_flip};
        row.n     = n;
        row.check = chk;
        return row;
    endfunction

    // Random frame for the current registers. Mostly well formed with random
    // content; the rest is broken in one way or another, or plain line noise.
    function automatic void compose_frame();
        int pick;
        int lim;
        int n;
        int lane;
        int at;
        int mode;
        int cut;
        logic [7:0]  ft;
        logic [7:0]  acc;
        logic [39:0] hdr;
        frame_bytes.delete();
        pick = $urandom_range(99);
        lim  = len_limit();
        if (pick >= 94)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                frame_bytes.push_back(8'($urandom));
            return;
        end
        lane = $urandom_range(7);
        ft   = reg_types[8*lane +: 8];
        if (pick >= 84 && pick < 88)
            ft = unknown_type();
        // mostly short payloads, now and then the full allowed length
        n   = ($urandom_range(7) == 0) ? lim : $urandom_range(0, (lim < 4) ? lim : 4);
        hdr = {reg_sync, ft, reg_preamble, 8'(n)};
        for (int i = 4; i >= 0; i--)
            frame_bytes.push_back(hdr[8*i +: 8]);
        if (pick >= 88 && pick < 92)
        begin
            at = $urandom_range(2, 3);
            frame_bytes[at] = frame_bytes[at] ^ 8'($urandom_range(1, 255));
        end
        if (pick >= 92)
            frame_bytes[4] = 8'($urandom_range(lim + 1, 255));
        mode = $urandom_range(7);
        for (int k = 0; k < n; k++)
            frame_bytes.push_back((mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom));
        acc = 8'h00;
        foreach (frame_bytes[i])
            acc = acc + frame_bytes[i];
        frame_bytes.push_back(check_of(acc) ^ ((pick >= 78 && pick < 84)
                                              ? 8'($urandom_range(1, 255)) : 8'h00));
        // truncated frame: whatever follows runs into it
        if (pick >= 72 && pick < 78)
        begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
    endfunction

    // Entered and left at a falling edge. Valid is only lowered when a gap is
    // taken, so back-to-back beats keep it high.
    task automatic send_byte(input logic [7:0] b, input bit use_model);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deframe_byte(b);
        if (use_model)
        begin
            foreach (frame_out[i])
                due_beats.push_back(frame_out[i]);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Sender holds off until every owed beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (due_beats.size() != 0);
    endtask

    task automatic put_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfr_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
    endtask

    // Quiet the block, then load a full register set and pick the idling mix
    task automatic next_phase(input logic [7:0] s, input logic [15:0] p, input logic [4:0] m,
                              input logic [63:0] t, input int in_pct, input int out_pct);
        drain_results();
        repeat (SETTLE)
            @(negedge clk);
        put_reg(sfr_pkg::CFG_SYNC, 64'(s));
        put_reg(sfr_pkg::CFG_PREAMBLE, 64'(p));
        put_reg(sfr_pkg::CFG_MAX_LEN, 64'(m));
        put_reg(sfr_pkg::CFG_TYPES, t);
        cfg_we       <= 1'b0;
        reg_sync     = s;
        reg_preamble = p;
        reg_max_len  = m;
        reg_types    = t;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        settings_run++;
    endtask

    // Random frames up to the byte budget, with one full drain half way through;
    // afterwards the parser is walked back to sync hunting.
    task automatic run_traffic(input int budget);
        int  sent;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget)
        begin
            compose_frame();
            foreach (frame_bytes[i])
                send_byte(frame_bytes[i], 1'b1);
            sent += frame_bytes.size();
            if (!paused && sent >= budget / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
        while (frame_pos != 5'd0)
            send_byte(leave_frame_byte(), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, and the scoreboard check on every beat taken
    // ------------------------------------------------------------------

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_idle_pct);

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_beats.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected nothing, %s 0x%0h idx %0d 0x%0h",
                         $time, "got type", frame_type, byte_index, data_byte);
            end
            else
            begin
                want = due_beats.pop_front();
                check_field("frame_type", want.kind, frame_type);
                check_field("frame_length", 8'(want.len), 8'(frame_length));
                check_field("byte_index", 8'(want.pos), 8'(byte_index));
                check_field("data_byte", want.value, data_byte);
                check_field("has_data", 8'(want.with_data), 8'(has_data));
                check_field("last", 8'(want.tail), 8'(last));
                beats_checked++;
                if (last)
                    frames_out++;
            end
        end
    end

    // Watchdog: any beat or register write counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d beats still owed",
                     $time, QUIET_LIMIT, due_beats.size());
            $display("serial_frame_receiver_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [7:0] t_lo;
        logic [7:0] t_hi;
        int         directed_bytes;

        model_reset();
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table at reset register values: noise at both ends of the
        // byte range, each way of dropping a frame, and the empty frame.
        t_lo = sfr_pkg::TYPES_RESET[7:0];
        t_hi = sfr_pkg::TYPES_RESET[63:56];
        stim_rows.push_back(make_row(8'h00, t_lo, sfr_pkg::PREAMBLE_RESET, 8'd0, 8'h00,
                                     1, CHK_NONE));
        stim_rows.push_back(make_row(8'hFF, t_lo, sfr_pkg::PREAMBLE_RESET, 8'd0, 8'h00,
                                     1, CHK_NONE));
        stim_rows.push_back(make_row(sfr_pkg::SYNC_RESET, unknown_type(),
                                     sfr_pkg::PREAMBLE_RESET, 8'd0, 8'h00, 2, CHK_NONE));
        stim_rows.push_back(make_row(sfr_pkg::SYNC_RESET, t_lo,
                                     sfr_pkg::PREAMBLE_RESET ^ 16'hFF00, 8'd0, 8'h00,
                                     3, CHK_NONE));
        stim_rows.push_back(make_row(sfr_pkg::SYNC_RESET, t_lo,
                                     sfr_pkg::PREAMBLE_RESET ^ 16'h00FF, 8'd0, 8'h00,
                                     4, CHK_NONE));
        // one past the length cap
        stim_rows.push_back(make_row(sfr_pkg::SYNC_RESET, t_lo, sfr_pkg::PREAMBLE_RESET,
                                     8'd17, 8'h00, 5, CHK_NONE));
        stim_rows.push_back(make_row(sfr_pkg::SYNC_RESET, t_hi, sfr_pkg::PREAMBLE_RESET,
                                     8'd0, 8'h00, 6, CHK_EMPTY));
        // bad checksum on an otherwise good empty frame
        stim_rows.push_back(make_row(sfr_pkg::SYNC_RESET, t_lo, sfr_pkg::PREAMBLE_RESET,
                                     8'd0, 8'h80, 6, CHK_NONE));

        foreach (stim_rows[r])
        begin
            for (int i = 0; i < stim_rows[r].n; i++)
                send_byte(stim_rows[r].seq[i], 1'b0);
            if (stim_rows[r].check == CHK_EMPTY)
                due_beats.push_back('{stim_rows[r].seq[1], 5'd0, 4'd0, 8'd0, 1'b0, 1'b1});
        end
        directed_bytes = bytes_sent;

        // Sender gaps light, result stall heavy
        run_traffic(PHASE_BYTES);
        next_phase(8'h00, 16'hFFFF, 5'd16, '1, 16, 60);
        run_traffic(PHASE_BYTES);

        // The other way round; the zero-length cap allows empty frames only
        next_phase(8'hFF, 16'h0000, 5'd0, 64'h0, 60, 16);
        run_traffic(PHASE_BYTES);
        next_phase(8'($urandom), 16'($urandom), 5'($urandom_range(1, 16)),
                   {$urandom, $urandom}, 60, 16);
        run_traffic(PHASE_BYTES);

        // No idling on either side
        next_phase(8'($urandom), 16'($urandom), 5'($urandom_range(1, 16)),
                   {$urandom, $urandom}, 0, 0);
        run_traffic(PHASE_BYTES);
        next_phase(sfr_pkg::SYNC_RESET, sfr_pkg::PREAMBLE_RESET, 5'd16,
                   {$urandom, $urandom}, 0, 0);
        run_traffic(PHASE_BYTES);

        drain_results();
        repeat (SETTLE)
            @(negedge clk);

        $display("covered %0d rx bytes (%0d directed), %0d result beats in %0d frames",
                 bytes_sent, directed_bytes, beats_checked, frames_out);
        $display("register sets: defaults plus %0d written, all-0/all-1 codes, caps 0 and 16",
                 settings_run);
        if (mismatches == 0 && due_beats.size() == 0)
            $display("serial_frame_receiver_test: PASS");
        else
            $display("serial_frame_receiver_test: FAIL");
        $finish;
    end

endmodule
